>>> rtl/lkv_pkg.sv
// shared constants and types for the lru key/value cache
`default_nettype none

package lkv_pkg;

  // default geometry
  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // capacity register
  localparam int              CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // result data width on the master side
  localparam int READ_W = 32;

  // request kinds carried in s_tuser
  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_GET = 1'b1;

  // result status carried in m_tuser
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  // request sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESULT
  } lkv_state_t;

endpackage

`default_nettype wire

>>> rtl/lkv_value_ram.sv
// value memory: one write port, one registered read port
`default_nettype none

module lkv_value_ram #(
  parameter int ENTRIES    = 16,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 4
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [IDX_W-1:0]      waddr,
  input  wire logic [VALUE_BITS-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [IDX_W-1:0]      raddr,
  output logic      [VALUE_BITS-1:0] rdata
);

  logic [VALUE_BITS-1:0] mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lkv_tag_array.sv
// key registers, recency ranks, fill count and capacity register
`default_nettype none

module lkv_tag_array #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32,
  parameter int IDX_W    = 4,
  parameter int COUNT_W  = 5
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
  input  wire logic                      update_en,
  input  wire logic                      action,
  input  wire logic [KEY_BITS-1:0]       key,
  output logic                           hit,
  output logic      [IDX_W-1:0]          hit_idx,
  output logic      [IDX_W-1:0]          target_idx
);

  import lkv_pkg::*;

  logic [KEY_BITS-1:0] keys [ENTRIES];
  logic [IDX_W-1:0]    ages [ENTRIES];
  logic [COUNT_W-1:0]  count;
  logic [CAP_W-1:0]    capacity;

  logic [COUNT_W-1:0] cap_eff;
  logic               fill;
  logic [IDX_W-1:0]   hit_age;
  logic [IDX_W-1:0]   victim_idx;
  logic [IDX_W-1:0]   oldest_age;
  logic [IDX_W-1:0]   old_age;
  logic               do_update;
  logic               do_write;

  // effective capacity: zero acts as one, above the entry count is clipped
  always_comb begin
    if (capacity == '0) begin
      cap_eff = COUNT_W'(1);
    end else if (int'(capacity) > ENTRIES) begin
      cap_eff = COUNT_W'(ENTRIES);
    end else begin
      cap_eff = COUNT_W'(capacity);
    end
  end

  // valid entries are always 0..count-1, so the oldest one has rank count-1
  assign oldest_age = IDX_W'(count - COUNT_W'(1));
  assign fill       = (count < cap_eff);

  // parallel key compare and rank match; valid keys are distinct
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    hit_age    = '0;
    victim_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (COUNT_W'(i) < count) begin
        if (keys[i] == key) begin
          hit     = 1'b1;
          hit_idx = hit_idx | IDX_W'(i);
          hit_age = hit_age | ages[i];
        end
        if (ages[i] == oldest_age) begin
          victim_idx = victim_idx | IDX_W'(i);
        end
      end
    end
  end

  // entry to touch and its rank before the touch
  always_comb begin
    if (hit) begin
      target_idx = hit_idx;
      old_age    = hit_age;
    end else if (fill) begin
      target_idx = IDX_W'(count);
      old_age    = IDX_W'(count);
    end else begin
      target_idx = victim_idx;
      old_age    = oldest_age;
    end
  end

  assign do_write  = update_en && (action == ACT_PUT);
  assign do_update = update_en && ((action == ACT_PUT) || hit);

  // capacity register and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
      count    <= '0;
    end else if (do_write && !hit && fill) begin
      count <= count + COUNT_W'(1);
    end
  end

  // key write and recency update
  always_ff @(posedge clk) begin
    if (do_write) begin
      keys[target_idx] <= key;
    end
    if (do_update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == target_idx) begin
          ages[i] <= '0;
        end else if ((COUNT_W'(i) < count) && (ages[i] < old_age)) begin
          ages[i] <= ages[i] + IDX_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
//
// Slave beat: s_tuser is the request kind (put or get), s_tdata holds the
// key in the low bits and the value above it. Master beat: m_tuser is the
// status (miss on a get that finds nothing), m_tdata the value read, zero
// on a put or a miss. One result beat per request beat, in order.
// Each request passes through capture, then key compare with the update of
// keys, ranks and the value memory, then the registered value-memory read
// is loaded into the output register. The next request is taken in the
// cycle after the result is loaded, so a new request is not accepted
// before the previous one has loaded its result.
// The output register holds a finished result while the master side
// stalls; the next request is accepted and worked on meanwhile and waits
// in its result step until the output register is free.
// Reset sets capacity to 16 and empties the store. Writing capacity
// through cfg_we/cfg_wdata also empties the store; write only when idle.
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF,
  localparam int S_TDATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration: capacity
  input  wire logic                      cfg_we,
  input  wire logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
  // request stream
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [S_TDATA_W-1:0]      s_tdata,  // key, value
  input  wire logic                      s_tuser,  // action
  // result stream
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [lkv_pkg::READ_W-1:0]     m_tdata,  // read_value
  output logic                           m_tuser   // status
);

  import lkv_pkg::*;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_W = $clog2(ENTRIES + 1);

  lkv_state_t state, state_next;

  logic                  req_action;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;
  logic                  req_miss;

  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      target_idx;
  logic [VALUE_BITS-1:0] rdata;
  logic [63:0]           rdata_wide;

  logic in_fire;
  logic lookup;
  logic load_out;

  assign in_fire  = s_tvalid && s_tready;
  assign lookup   = (state == ST_LOOKUP);

  // key registers and recency ranks
  lkv_tag_array #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W),
    .COUNT_W  (COUNT_W)
  ) u_tags (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .update_en  (lookup),
    .action     (req_action),
    .key        (req_key),
    .hit        (hit),
    .hit_idx    (hit_idx),
    .target_idx (target_idx)
  );

  // value storage
  lkv_value_ram #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W)
  ) u_values (
    .clk   (clk),
    .we    (lookup && (req_action == ACT_PUT)),
    .waddr (target_idx),
    .wdata (req_value),
    .re    (lookup),
    .raddr (hit_idx),
    .rdata (rdata)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_action <= s_tuser;
      req_key    <= s_tdata[KEY_BITS-1:0];
      req_value  <= s_tdata[KEY_BITS +: VALUE_BITS];
    end
    if (lookup) begin
      req_miss <= (req_action == ACT_GET) && !hit;
    end
  end

  assign rdata_wide = 64'(rdata);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= req_miss ? STATUS_MISS : STATUS_OK;
      if ((req_action == ACT_GET) && !req_miss) begin
        m_tdata <= rdata_wide[READ_W-1:0];
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

`default_nettype wire
